@@ hw/rtl/dss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the door step sequencer
// Holds function codes, blink pattern constants and the command structs
// passed between the sequencer and its submodules.
// ----------------------------------------------------------------------------
package dss_pkg;

    typedef enum logic [2:0] {
        FUNC_TICK        = 3'd0,
        FUNC_OPEN        = 3'd1,
        FUNC_SHORT_ALERT = 3'd2,
        FUNC_LONG_ALERT  = 3'd3,
        FUNC_TABLE_WRITE = 3'd4
    } func_t;

    typedef enum logic {
        CFG_SLOW_OPEN  = 1'b0,
        CFG_SLOW_CLOSE = 1'b1
    } cfg_index_t;

    // Range of the table_addr field.
    localparam int unsigned ADDR_RANGE = 64;

    localparam logic [3:0] EDGE_MASK     = 4'hf;
    localparam logic [3:0] EDGE_PATTERN  = 4'h7;
    localparam logic [2:0] POST_RELOAD   = 3'd4;
    localparam logic [4:0] SHORT_ON      = 5'd10;
    localparam logic [4:0] LONG_ON       = 5'd20;
    localparam logic [2:0] SHORT_REPEATS = 3'd3;
    localparam logic [2:0] LONG_REPEATS  = 3'd5;
    localparam logic [4:0] BLINK_OFF     = 5'd5;
    localparam logic [2:0] SLOW_PHASE    = 3'd1;

    typedef struct packed {
        logic tick;
        logic start_short;
        logic start_long;
    } blink_cmd_t;

    typedef struct packed {
        logic [7:0] outputs;
        logic [7:0] dwell;
    } step_entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/dss_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_table: step table memory
// One write port and one registered read port; a write to the address being
// read in the same cycle is forwarded to the read register.
// ----------------------------------------------------------------------------
module dss_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX_W = 6
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [IDX_W-1:0]          wr_addr,
    input  dss_pkg::step_entry_t     wr_data,
    input  wire [IDX_W-1:0]          rd_addr,
    output dss_pkg::step_entry_t     rd_data
);

    dss_pkg::step_entry_t mem [DEPTH];
    dss_pkg::step_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/dss_blink.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_blink: alert blinker
// Runs the short or long on/off pattern a fixed number of times, one count
// per tick. The level output is the value after the current command.
// ----------------------------------------------------------------------------
module dss_blink (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  dss_pkg::blink_cmd_t  cmd,
    output logic                 level_next
);

    logic       on_phase_reg, on_phase_next;
    logic [2:0] repeats_reg, repeats_next;
    logic [4:0] count_reg, count_next;
    logic [4:0] on_len_reg, on_len_next;
    logic       level_reg;
    logic [4:0] count_dec;

    always_comb begin
        on_phase_next = on_phase_reg;
        repeats_next  = repeats_reg;
        count_next    = count_reg;
        on_len_next   = on_len_reg;
        level_next    = level_reg;
        count_dec     = count_reg - 5'd1;

        if (cmd.start_short || cmd.start_long) begin
            on_phase_next = 1'b1;
            repeats_next  = cmd.start_long ? dss_pkg::LONG_REPEATS : dss_pkg::SHORT_REPEATS;
            on_len_next   = cmd.start_long ? dss_pkg::LONG_ON : dss_pkg::SHORT_ON;
            count_next    = on_len_next;
        end else if (cmd.tick && (repeats_reg != 3'd0)) begin
            count_next = count_dec;
            if (on_phase_reg) begin
                level_next = 1'b1;
                if (count_dec == 5'd0) begin
                    on_phase_next = 1'b0;
                    count_next    = dss_pkg::BLINK_OFF;
                end
            end else begin
                level_next = 1'b0;
                if (count_dec == 5'd0) begin
                    on_phase_next = 1'b1;
                    count_next    = on_len_reg;
                    repeats_next  = repeats_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_phase_reg <= 1'b0;
            repeats_reg  <= 3'd0;
            count_reg    <= 5'd0;
            on_len_reg   <= 5'd0;
            level_reg    <= 1'b0;
        end else begin
            on_phase_reg <= on_phase_next;
            repeats_reg  <= repeats_next;
            count_reg    <= count_next;
            on_len_reg   <= on_len_next;
            level_reg    <= level_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/door_step_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// door_step_sequencer: tick-driven door step sequencer
// Steps through a loaded table of output bytes and dwell times, with limit
// switch debouncing, slow-speed pulsing and an alert blinker.
// ----------------------------------------------------------------------------
// The block takes one input word per clock and returns exactly one result
// word for it in the cycle after acceptance, from the output register. All
// of the state update is combinational between the state registers and
// that output register; the step table read is registered and always points
// at the current step, so a step load waits for no table read. Input is
// stalled only while the output register holds a word not yet taken.
module door_step_sequencer #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_addr,
    input  wire  [7:0]  cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [2:0] func, [3] open_switch, [4] close_switch, [10:5] table_addr,
    // [18:11] table_outputs, [26:19] table_time, [31:27] zero
    input  wire  [31:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] main_drive, [4:1] aux_drives, [5] alert_out, [6] door_running,
    // [7] report_opened, [8] report_closed, [15:9] zero
    output logic [15:0] m_tdata
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Input fields.
    logic [2:0] in_func;
    logic       in_osw, in_csw;
    logic [5:0] in_addr;
    logic [7:0] in_outputs, in_time;
    logic       in_acc;

    assign in_func    = s_tdata[2:0];
    assign in_osw     = s_tdata[3];
    assign in_csw     = s_tdata[4];
    assign in_addr    = s_tdata[10:5];
    assign in_outputs = s_tdata[18:11];
    assign in_time    = s_tdata[26:19];

    // Configuration registers.
    logic [7:0] slow_open_reg, slow_close_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_open_reg  <= 8'd0;
            slow_close_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            case (dss_pkg::cfg_index_t'(cfg_addr))
                dss_pkg::CFG_SLOW_OPEN:  slow_open_reg  <= cfg_wdata;
                dss_pkg::CFG_SLOW_CLOSE: slow_close_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Table addresses wrap modulo the table depth; precomputed per address.
    logic [IDX_W-1:0] addr_wrap [dss_pkg::ADDR_RANGE];

    for (genvar g = 0; g < dss_pkg::ADDR_RANGE; g++) begin : g_wrap
        assign addr_wrap[g] = IDX_W'(g % TABLE_DEPTH);
    end

    // Sequencer state.
    logic             running_reg, running_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [7:0]       dwell_reg, dwell_next;
    logic [2:0]       prescale_reg, prescale_next;
    logic [7:0]       open_hist_reg, open_hist_next;
    logic [7:0]       close_hist_reg, close_hist_next;
    logic [7:0]       slow_reg, slow_next;
    logic             limits_reg, limits_next;
    logic             reverse_reg, reverse_next;
    logic [4:0]       drive_reg, drive_next;
    logic             rep_opened, rep_closed;
    logic [7:0]       slow_dec;

    dss_pkg::step_entry_t cur_entry;
    dss_pkg::step_entry_t wr_entry;
    dss_pkg::blink_cmd_t  blink_cmd;
    logic                 tbl_wr_en;
    logic                 blink_level;

    assign wr_entry.outputs = in_outputs;
    assign wr_entry.dwell   = in_time;
    assign tbl_wr_en = in_acc && (in_func == dss_pkg::FUNC_TABLE_WRITE);

    assign blink_cmd.tick        = in_acc && (in_func == dss_pkg::FUNC_TICK);
    assign blink_cmd.start_short = in_acc && (in_func == dss_pkg::FUNC_SHORT_ALERT);
    assign blink_cmd.start_long  = in_acc && (in_func == dss_pkg::FUNC_LONG_ALERT);

    always_comb begin
        running_next    = running_reg;
        step_next       = step_reg;
        dwell_next      = dwell_reg;
        prescale_next   = prescale_reg;
        open_hist_next  = open_hist_reg;
        close_hist_next = close_hist_reg;
        slow_next       = slow_reg;
        limits_next     = limits_reg;
        reverse_next    = reverse_reg;
        drive_next      = drive_reg;
        rep_opened      = 1'b0;
        rep_closed      = 1'b0;
        slow_dec        = slow_reg - 8'd1;

        if (in_acc) begin
            case (dss_pkg::func_t'(in_func))
                dss_pkg::FUNC_TICK: begin
                    open_hist_next  = {open_hist_reg[6:0], in_osw};
                    close_hist_next = {close_hist_reg[6:0], in_csw};

                    // Slow speed: aux drive bit 1 pulses once every eight ticks.
                    if (slow_reg != 8'd0) begin
                        slow_next     = slow_dec;
                        drive_next[2] = (slow_dec[2:0] == dss_pkg::SLOW_PHASE);
                    end
                    if (((open_hist_next[3:0] & dss_pkg::EDGE_MASK) == dss_pkg::EDGE_PATTERN)
                            && limits_reg) begin
                        dwell_next = 8'd0;
                        slow_next  = slow_open_reg;
                    end
                    if (((close_hist_next[3:0] & dss_pkg::EDGE_MASK) == dss_pkg::EDGE_PATTERN)
                            && limits_reg) begin
                        dwell_next = 8'd0;
                        slow_next  = slow_close_reg;
                    end

                    if (prescale_reg == 3'd0) begin
                        prescale_next = dss_pkg::POST_RELOAD;
                        if (!running_reg) begin
                            step_next  = '0;
                            dwell_next = 8'd0;
                        end else if (dwell_next == 8'd0) begin
                            dwell_next = cur_entry.dwell;
                            if (cur_entry.dwell == 8'd0) begin
                                running_next = 1'b0;
                            end
                            step_next = (step_reg == IDX_W'(TABLE_DEPTH - 1))
                                        ? '0 : step_reg + 1'b1;
                            drive_next   = {cur_entry.outputs[6:3], cur_entry.outputs[0]};
                            limits_next  = cur_entry.outputs[2];
                            reverse_next = cur_entry.outputs[7];
                            rep_closed   = cur_entry.outputs[1];
                        end else begin
                            dwell_next = dwell_next - 8'd1;
                        end
                    end else begin
                        prescale_next = prescale_reg - 3'd1;
                    end
                end
                dss_pkg::FUNC_OPEN: begin
                    if (!running_reg) begin
                        running_next    = 1'b1;
                        open_hist_next  = {7'd0, in_osw};
                        close_hist_next = {7'd0, in_csw};
                        rep_opened      = 1'b1;
                    end else if (reverse_reg) begin
                        dwell_next = 8'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= 1'b0;
            step_reg       <= '0;
            dwell_reg      <= 8'd0;
            prescale_reg   <= 3'd0;
            open_hist_reg  <= 8'd0;
            close_hist_reg <= 8'd0;
            slow_reg       <= 8'd0;
            limits_reg     <= 1'b0;
            reverse_reg    <= 1'b0;
            drive_reg      <= 5'd0;
        end else begin
            running_reg    <= running_next;
            step_reg       <= step_next;
            dwell_reg      <= dwell_next;
            prescale_reg   <= prescale_next;
            open_hist_reg  <= open_hist_next;
            close_hist_reg <= close_hist_next;
            slow_reg       <= slow_next;
            limits_reg     <= limits_next;
            reverse_reg    <= reverse_next;
            drive_reg      <= drive_next;
        end
    end

    // The read address follows the next step so the entry is ready next cycle.
    dss_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (addr_wrap[in_addr]),
        .wr_data (wr_entry),
        .rd_addr (step_next),
        .rd_data (cur_entry)
    );

    dss_blink u_blink (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (blink_cmd),
        .level_next (blink_level)
    );

    // Output register.
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_acc) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            m_tdata_reg <= {7'd0, rep_closed, rep_opened, running_next, blink_level,
                            drive_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the door step sequencer
// Loads the step table, walks a short table of directed words and then four
// phases of random words under different slow-speed counts. Every result word
// is compared field by field with a preset or an in-bench sequencer model.
// ----------------------------------------------------------------------------
module tb_top;
    import dss_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 300_000;
    localparam int PHASE_WORDS    = 400;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 10;

    // Function codes the block ignores.
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    // Input word layout, func in the lowest bits.
    typedef struct packed {
        logic [7:0] table_time;
        logic [7:0] table_outputs;
        logic [5:0] table_addr;
        logic       close_switch;
        logic       open_switch;
        logic [2:0] func;
    } door_cmd_t;

    // Result word layout, main_drive in bit 0.
    typedef struct packed {
        logic       report_closed;
        logic       report_opened;
        logic       door_running;
        logic       alert_out;
        logic [3:0] aux_drives;
        logic       main_drive;
    } door_status_t;

    typedef struct packed {
        logic         fixed;
        door_status_t status;
    } preset_t;

    typedef struct packed {
        logic [2:0]   func;
        logic         osw;
        logic         csw;
        logic [5:0]   addr;
        logic [7:0]   outs;
        logic [7:0]   dwell;
        logic         fixed;
        door_status_t status;
    } dir_row_t;

    localparam door_status_t ST_IDLE   = '0;
    localparam door_status_t ST_OPENED = '{report_opened: 1'b1, door_running: 1'b1,
                                           default: 1'b0};

    // Step 0 enables limits and reverse, step 1 ends the run with a closed
    // report. The three ticks with both switches high, starting with the one
    // that loads step 0, give both limit edges at once.
    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{FUNC_TICK,        1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b1, ST_IDLE},
        '{FUNC_SPARE_LO,    1'b1, 1'b1, 6'd63, 8'hff, 8'd255, 1'b1, ST_IDLE},
        '{FUNC_SPARE_HI,    1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b1, ST_IDLE},
        '{FUNC_TABLE_WRITE, 1'b0, 1'b0, 6'd63, 8'hff, 8'd255, 1'b1, ST_IDLE},
        '{FUNC_TABLE_WRITE, 1'b1, 1'b1, 6'd0,  8'h85, 8'd2,   1'b1, ST_IDLE},
        '{FUNC_TABLE_WRITE, 1'b0, 1'b0, 6'd1,  8'h7a, 8'd0,   1'b1, ST_IDLE},
        '{FUNC_SHORT_ALERT, 1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b1, ST_IDLE},
        '{FUNC_OPEN,        1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b1, ST_OPENED},
        '{FUNC_TICK,        1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_OPEN,        1'b1, 1'b1, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_LONG_ALERT,  1'b1, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b1, 1'b1, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b1, 1'b1, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b1, 1'b1, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b1, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b1, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_OPEN,        1'b0, 1'b0, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE},
        '{FUNC_TICK,        1'b0, 1'b1, 6'd0,  8'h00, 8'd0,   1'b0, ST_IDLE}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    door_step_sequencer #(
        .TABLE_DEPTH(ADDR_RANGE)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #(CLK_PERIOD / 2);
        aclk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Model state of the sequencer.
    logic [7:0]  slow_open_cnt;
    logic [7:0]  slow_close_cnt;
    logic        running;
    logic [5:0]  step_number;
    logic [7:0]  dwell_left;
    logic [2:0]  prescale;
    logic [7:0]  open_hist;
    logic [7:0]  close_hist;
    logic [7:0]  slow_left;
    logic        limits_en;
    logic        reverse_en;
    logic [4:0]  drives;
    logic        blink_on;
    logic [2:0]  blink_reps;
    logic [4:0]  blink_cnt;
    logic [4:0]  blink_on_len;
    logic        blink_level;
    step_entry_t step_tbl [ADDR_RANGE];

    door_status_t pending_status_q[$];
    preset_t      typed_status_q[$];
    int           mismatches = 0;

    // Stimulus controls; calm and long_hold_req are shared with the receiver.
    bit          calm = 1'b0;
    bit          long_hold_req = 1'b0;
    logic        open_lvl = 1'b0;
    logic        close_lvl = 1'b0;

    function automatic door_status_t next_door_status(door_cmd_t c);
        door_status_t r;
        step_entry_t  ent;
        logic         opened;
        logic         closed;
        opened = 1'b0;
        closed = 1'b0;
        case (c.func)
            FUNC_TICK: begin
                open_hist  = {open_hist[6:0], c.open_switch};
                close_hist = {close_hist[6:0], c.close_switch};
                if (slow_left != 8'd0) begin
                    slow_left = slow_left - 8'd1;
                    drives[2] = (slow_left[2:0] == SLOW_PHASE);
                end
                if ((open_hist[3:0] & EDGE_MASK) == EDGE_PATTERN && limits_en) begin
                    dwell_left = 8'd0;
                    slow_left  = slow_open_cnt;
                end
                // The close edge is checked last so that it wins a tie.
                if ((close_hist[3:0] & EDGE_MASK) == EDGE_PATTERN && limits_en) begin
                    dwell_left = 8'd0;
                    slow_left  = slow_close_cnt;
                end
                if (prescale == 3'd0) begin
                    prescale = POST_RELOAD;
                    if (!running) begin
                        step_number = 6'd0;
                        dwell_left  = 8'd0;
                    end else if (dwell_left == 8'd0) begin
                        ent         = step_tbl[step_number];
                        dwell_left  = ent.dwell;
                        if (ent.dwell == 8'd0)
                            running = 1'b0;
                        step_number = step_number + 6'd1;
                        drives      = {ent.outputs[6:3], ent.outputs[0]};
                        limits_en   = ent.outputs[2];
                        reverse_en  = ent.outputs[7];
                        closed      = ent.outputs[1];
                    end else begin
                        dwell_left = dwell_left - 8'd1;
                    end
                end else begin
                    prescale = prescale - 3'd1;
                end
                if (blink_reps != 3'd0) begin
                    blink_cnt = blink_cnt - 5'd1;
                    if (blink_on) begin
                        blink_level = 1'b1;
                        if (blink_cnt == 5'd0) begin
                            blink_on  = 1'b0;
                            blink_cnt = BLINK_OFF;
                        end
                    end else begin
                        blink_level = 1'b0;
                        if (blink_cnt == 5'd0) begin
                            blink_on   = 1'b1;
                            blink_cnt  = blink_on_len;
                            blink_reps = blink_reps - 3'd1;
                        end
                    end
                end
            end
            FUNC_OPEN: begin
                if (!running) begin
                    running    = 1'b1;
                    open_hist  = {7'd0, c.open_switch};
                    close_hist = {7'd0, c.close_switch};
                    opened     = 1'b1;
                end else if (reverse_en) begin
                    dwell_left = 8'd0;
                end
            end
            FUNC_SHORT_ALERT, FUNC_LONG_ALERT: begin
                blink_on     = 1'b1;
                blink_reps   = (c.func == FUNC_SHORT_ALERT) ? SHORT_REPEATS : LONG_REPEATS;
                blink_on_len = (c.func == FUNC_SHORT_ALERT) ? SHORT_ON : LONG_ON;
                blink_cnt    = blink_on_len;
            end
            FUNC_TABLE_WRITE: begin
                step_tbl[c.table_addr] = {c.table_outputs, c.table_time};
            end
            default: ;
        endcase
        r.main_drive    = drives[0];
        r.aux_drives    = drives[4:1];
        r.alert_out     = blink_level;
        r.door_running  = running;
        r.report_opened = opened;
        r.report_closed = closed;
        return r;
    endfunction

    // Inputs are taken before results so that the expectation is queued first.
    always @(posedge aclk) begin
        door_status_t want;
        door_status_t got;
        preset_t      p;
        if (!aresetn) begin
            slow_open_cnt  = 8'd0;
            slow_close_cnt = 8'd0;
            running        = 1'b0;
            step_number    = 6'd0;
            dwell_left     = 8'd0;
            prescale       = 3'd0;
            open_hist      = 8'd0;
            close_hist     = 8'd0;
            slow_left      = 8'd0;
            limits_en      = 1'b0;
            reverse_en     = 1'b0;
            drives         = 5'd0;
            blink_on       = 1'b0;
            blink_reps     = 3'd0;
            blink_cnt      = 5'd0;
            blink_on_len   = 5'd0;
            blink_level    = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SLOW_CLOSE)
                    slow_close_cnt = cfg_wdata;
                else
                    slow_open_cnt = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                want = next_door_status(door_cmd_t'(s_tdata[26:0]));
                p    = typed_status_q.pop_front();
                if (p.fixed)
                    want = p.status;
                pending_status_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = door_status_t'(m_tdata[8:0]);
                if (pending_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word %h with nothing expected", $realtime, got);
                end else begin
                    want = pending_status_q.pop_front();
                    if (got.main_drive !== want.main_drive ||
                        got.aux_drives !== want.aux_drives ||
                        got.alert_out !== want.alert_out ||
                        got.door_running !== want.door_running ||
                        got.report_opened !== want.report_opened ||
                        got.report_closed !== want.report_closed) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("%0t: mismatch main/aux/alert/run/opened/closed ",
                                   $realtime);
                            $display("expected %b/%h/%b/%b/%b/%b got %b/%h/%b/%b/%b/%b",
                                     want.main_drive, want.aux_drives,
                                     want.alert_out, want.door_running,
                                     want.report_opened, want.report_closed,
                                     got.main_drive, got.aux_drives, got.alert_out,
                                     got.door_running, got.report_opened,
                                     got.report_closed);
                        end
                    end
                end
            end
        end
    end

    // Drives one word and returns at the edge that accepts it, leaving
    // s_tvalid high so that the next word can follow without a gap.
    task automatic send_word(input door_cmd_t c, input logic fixed, input door_status_t st);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        typed_status_q.push_back('{fixed: fixed, status: st});
        s_tdata  <= 32'(c);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_status_q.size() != 0);
    endtask

    // Mostly short dwells, many run ends, now and then a long one.
    function automatic door_cmd_t table_word(logic [5:0] addr);
        door_cmd_t c;
        int        pick;
        c               = door_cmd_t'(27'($urandom));
        c.func          = FUNC_TABLE_WRITE;
        c.table_addr    = addr;
        c.table_outputs = 8'($urandom);
        pick            = $urandom_range(0, 99);
        if (pick < 35)
            c.table_time = 8'd0;
        else if (pick < 85)
            c.table_time = 8'($urandom_range(1, 4));
        else if (pick < 97)
            c.table_time = 8'($urandom_range(5, 20));
        else
            c.table_time = 8'($urandom);
        return c;
    endfunction

    function automatic door_cmd_t random_word();
        door_cmd_t c;
        int        pick;
        c    = door_cmd_t'(27'($urandom));
        pick = $urandom_range(0, 99);
        // Switch levels change slowly so that debounced edges actually occur.
        if ($urandom_range(0, 5) == 0)
            open_lvl = !open_lvl;
        if ($urandom_range(0, 5) == 0)
            close_lvl = !close_lvl;
        if ($urandom_range(0, 9) != 0) begin
            c.open_switch  = open_lvl;
            c.close_switch = close_lvl;
        end
        if (pick < 70)
            c.func = FUNC_TICK;
        else if (pick < 80)
            c = table_word(6'($urandom));
        else if (pick < 88)
            c.func = FUNC_OPEN;
        else if (pick < 92)
            c.func = FUNC_SHORT_ALERT;
        else if (pick < 95)
            c.func = FUNC_LONG_ALERT;
        else if (pick < 97)
            c.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else
            c.func = FUNC_TICK;
        return c;
    endfunction

    initial begin
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        logic [7:0] open_counts [4];
        logic [7:0] close_counts [4];
        door_cmd_t  c;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_SLOW_OPEN;
        cfg_wdata <= '0;
        open_counts  = '{8'd0, 8'd255, 8'($urandom_range(1, 24)), 8'($urandom)};
        close_counts = '{8'd255, 8'd0, 8'($urandom_range(1, 24)), 8'($urandom)};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            repeat (4) @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_SLOW_OPEN;
            cfg_wdata <= open_counts[ph];
            @(posedge aclk);
            cfg_addr  <= CFG_SLOW_CLOSE;
            cfg_wdata <= close_counts[ph];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            @(posedge aclk);
            if (ph == 0) begin
                // Every table entry is written before any run can read one.
                for (int a = 0; a < ADDR_RANGE; a++)
                    send_word(table_word(6'(a)), 1'b1, ST_IDLE);
                for (int i = 0; i < DIR_ROWS; i++) begin
                    c               = '0;
                    c.func          = DIRECTED[i].func;
                    c.open_switch   = DIRECTED[i].osw;
                    c.close_switch  = DIRECTED[i].csw;
                    c.table_addr    = DIRECTED[i].addr;
                    c.table_outputs = DIRECTED[i].outs;
                    c.table_time    = DIRECTED[i].dwell;
                    send_word(c, DIRECTED[i].fixed, DIRECTED[i].status);
                end
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                calm = (ph == 3) || (n >= 150 && n < 200);
                if (ph == 1 && n == 60)
                    long_hold_req = 1'b1;
                if (ph == 2 && n == 220)
                    drain();
                send_word(random_word(), 1'b0, ST_IDLE);
            end
        end
        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
